[sv/sd_spi_card_init_sequencer_macros.svh]
// Assertion helpers for the SD SPI init sequencer
`ifndef SD_SPI_CARD_INIT_SEQUENCER_MACROS_SVH
`define SD_SPI_CARD_INIT_SEQUENCER_MACROS_SVH

`define SDI_ASSERT_IMP(label, clk_s, rst_s, a, c) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (a) |-> (c)) \
    else $error("assertion failed");

`define SDI_ASSERT_NXT(label, clk_s, rst_s, a, c) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[sv/sdi_pkg.sv]
package sdi_pkg;
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_XFER  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_POWERUP    = 4'd1;
  localparam logic [3:0] PH_DUMMY      = 4'd2;
  localparam logic [3:0] PH_DESEL      = 4'd3;
  localparam logic [3:0] PH_WAIT_FIRST = 4'd4;
  localparam logic [3:0] PH_WAIT_READY = 4'd5;
  localparam logic [3:0] PH_FAIL_DESEL = 4'd6;
  localparam logic [3:0] PH_SEND       = 4'd7;
  localparam logic [3:0] PH_RESP       = 4'd8;
  localparam logic [3:0] PH_OCR        = 4'd9;
  localparam logic [3:0] PH_FINISH     = 4'd10;

  localparam logic [2:0] ST_CMD0    = 3'd0;
  localparam logic [2:0] ST_CMD8    = 3'd1;
  localparam logic [2:0] ST_SD2POLL = 3'd2;
  localparam logic [2:0] ST_CMD58   = 3'd3;
  localparam logic [2:0] ST_PROBE   = 3'd4;
  localparam logic [2:0] ST_OLDPOLL = 3'd5;
  localparam logic [2:0] ST_CMD16   = 3'd6;

  localparam logic [3:0] T_MMC   = 4'h1;
  localparam logic [3:0] T_SD1   = 4'h2;
  localparam logic [3:0] T_SD2   = 4'h4;
  localparam logic [3:0] T_BLOCK = 4'h8;

  localparam logic [2:0] REG_POWERUP = 3'd0;
  localparam logic [2:0] REG_INIT_TO = 3'd1;
  localparam logic [2:0] REG_READY_TO = 3'd2;
  localparam logic [2:0] REG_TRIES   = 3'd3;
  localparam logic [2:0] REG_DUMMY   = 3'd4;
  localparam logic [2:0] REG_BLKLEN  = 3'd5;

  // result item fields, highest bit first in tdata
  typedef struct packed {
    logic [3:0] card_type;
    logic       init_ok;
    logic       busy_res;
    logic       fast_clock;
    logic       select_low;
    logic [7:0] tx_byte;
    logic       exchange_pending;
  } result_t;
endpackage

[sv/sd_spi_card_init_sequencer.sv]
// The result item of an accepted input item is in the output register in the next cycle.
// Throughput: one item per cycle while results are taken; the whole step is one pass of next-state logic.
// The output register frees whenever the result is taken, so input and output overlap.
// Reset (rst, synchronous, active high): idle, no result pending, registers at defaults.
`include "sd_spi_card_init_sequencer_macros.svh"
module sd_spi_card_init_sequencer import sdi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cmd[1:0], rx_byte[9:2], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // exchange_pending, tx_byte[8:1], select_low, fast_clock,
                                 // busy_res, init_ok, card_type[16:13], zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  logic [7:0] powerup_ticks, init_timeout_ticks, ready_timeout_ticks, response_tries;
  logic [7:0] dummy_bytes;
  logic [12:0] block_length;

  logic [3:0] phase, phase_next;
  logic [7:0] byte_count, byte_count_next;
  logic [5:0] command_index, command_index_next;
  logic [31:0] command_arg, command_arg_next;
  logic app_prefix_pending, app_prefix_pending_next;
  logic [7:0] tries_left, tries_left_next;
  logic [7:0] init_timer, init_timer_next, ready_timer, ready_timer_next;
  logic [7:0] ocr_bytes [4];
  logic [7:0] ocr_bytes_next [4];
  logic [3:0] type_flags, type_flags_next;
  logic not_initialized, not_initialized_next, clock_fast, clock_fast_next;
  logic [2:0] init_step, init_step_next;
  logic [3:0] pending_type, pending_type_next;
  result_t res;

  logic [1:0] c;
  logic [7:0] rx;
  logic accept;
  assign c  = s_tdata[1:0];
  assign rx = s_tdata[9:2];
  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;

  always_comb begin
    logic cd;    // command finished, answer in r
    logic [7:0] r;
    logic op;    // old_poll requested
    logic sp;    // sd2_poll requested
    logic [5:0] idx;
    logic [31:0] arg;
    cd = 1'b0; r = 8'hFF; op = 1'b0; sp = 1'b0;
    phase_next = phase; byte_count_next = byte_count;
    command_index_next = command_index; command_arg_next = command_arg;
    app_prefix_pending_next = app_prefix_pending; tries_left_next = tries_left;
    init_timer_next = init_timer; ready_timer_next = ready_timer;
    ocr_bytes_next = ocr_bytes; type_flags_next = type_flags;
    not_initialized_next = not_initialized; clock_fast_next = clock_fast;
    init_step_next = init_step; pending_type_next = pending_type;
    if (c == CMD_START) begin
      clock_fast_next = 1'b0;
      app_prefix_pending_next = 1'b0;
      init_timer_next = powerup_ticks;
      phase_next = PH_POWERUP;
    end else if (c == CMD_TICK) begin
      if (init_timer != 8'd0) init_timer_next = init_timer - 8'd1;
      if (ready_timer != 8'd0) ready_timer_next = ready_timer - 8'd1;
    end else if (c == CMD_XFER) begin
      unique case (phase)
        PH_DUMMY: begin
          byte_count_next = byte_count - 8'd1;
          if (byte_count_next == 8'd0) begin
            command_index_next = 6'd0; command_arg_next = '0;
            app_prefix_pending_next = 1'b0; init_step_next = ST_CMD0;
            phase_next = PH_DESEL;
          end
        end
        PH_DESEL: begin
          ready_timer_next = ready_timeout_ticks;
          phase_next = PH_WAIT_FIRST;
        end
        PH_WAIT_FIRST: phase_next = PH_WAIT_READY;
        PH_WAIT_READY: begin
          if (rx == 8'hFF) begin
            phase_next = PH_SEND; byte_count_next = 8'd0;
          end else if (ready_timer == 8'd0) phase_next = PH_FAIL_DESEL;
        end
        PH_FAIL_DESEL: begin cd = 1'b1; r = 8'hFF; end
        PH_SEND: begin
          if (byte_count >= 8'd5) begin
            phase_next = PH_RESP; tries_left_next = response_tries;
          end else byte_count_next = byte_count + 8'd1;
        end
        PH_RESP: begin
          tries_left_next = tries_left - 8'd1;
          if (!rx[7] || tries_left_next == 8'd0) begin cd = 1'b1; r = rx; end
        end
        PH_OCR: begin
          ocr_bytes_next[byte_count[1:0]] = rx;
          byte_count_next = byte_count + 8'd1;
          if (byte_count_next >= 8'd4) begin
            if (init_step == ST_CMD8) begin
              if (ocr_bytes_next[2] == 8'h01 && ocr_bytes_next[3] == 8'hAA) sp = 1'b1;
              else begin type_flags_next = 4'd0; phase_next = PH_FINISH; end
            end else begin
              type_flags_next = ocr_bytes_next[0][6] ? (T_SD2 | T_BLOCK) : T_SD2;
              phase_next = PH_FINISH;
            end
          end
        end
        PH_FINISH: begin
          not_initialized_next = (type_flags == 4'd0);
          clock_fast_next = (type_flags != 4'd0);
          phase_next = PH_IDLE;
        end
        default: ;
      endcase
    end
    // response handling, APP_CMD prefix first
    if (cd && app_prefix_pending) begin
      app_prefix_pending_next = 1'b0;
      if (r <= 8'd1) begin phase_next = PH_DESEL; cd = 1'b0; end
    end
    if (cd) begin
      unique case (init_step)
        ST_CMD0: begin
          if (r == 8'd1) begin
            init_timer_next = init_timeout_ticks;
            command_index_next = 6'd8; command_arg_next = 32'h1AA;
            app_prefix_pending_next = 1'b0; init_step_next = ST_CMD8;
            phase_next = PH_DESEL;
          end else begin type_flags_next = 4'd0; phase_next = PH_FINISH; end
        end
        ST_CMD8: begin
          if (r == 8'd1) begin phase_next = PH_OCR; byte_count_next = 8'd0; end
          else begin
            command_index_next = 6'd41; command_arg_next = '0;
            app_prefix_pending_next = 1'b1; init_step_next = ST_PROBE;
            phase_next = PH_DESEL;
          end
        end
        ST_SD2POLL: begin
          if (r != 8'd0) sp = 1'b1;
          else if (init_timer != 8'd0) begin
            command_index_next = 6'd58; command_arg_next = '0;
            app_prefix_pending_next = 1'b0; init_step_next = ST_CMD58;
            phase_next = PH_DESEL;
          end else begin type_flags_next = 4'd0; phase_next = PH_FINISH; end
        end
        ST_CMD58: begin
          if (r == 8'd0) begin phase_next = PH_OCR; byte_count_next = 8'd0; end
          else begin type_flags_next = 4'd0; phase_next = PH_FINISH; end
        end
        ST_PROBE: begin
          pending_type_next = (r <= 8'd1) ? T_SD1 : T_MMC;
          op = 1'b1;
        end
        ST_OLDPOLL: begin
          if (r != 8'd0) op = 1'b1;
          else if (init_timer != 8'd0) begin
            command_index_next = 6'd16; command_arg_next = {19'd0, block_length};
            app_prefix_pending_next = 1'b0; init_step_next = ST_CMD16;
            phase_next = PH_DESEL;
          end else begin type_flags_next = 4'd0; phase_next = PH_FINISH; end
        end
        default: begin
          type_flags_next = (r == 8'd0) ? pending_type : 4'd0;
          phase_next = PH_FINISH;
        end
      endcase
    end
    if (sp) begin
      if (init_timer != 8'd0) begin
        command_index_next = 6'd41; command_arg_next = 32'h4000_0000;
        app_prefix_pending_next = 1'b1; init_step_next = ST_SD2POLL;
        phase_next = PH_DESEL;
      end else begin type_flags_next = 4'd0; phase_next = PH_FINISH; end
    end
    if (op) begin
      if (init_timer == 8'd0) begin type_flags_next = 4'd0; phase_next = PH_FINISH; end
      else begin
        command_arg_next = '0; init_step_next = ST_OLDPOLL; phase_next = PH_DESEL;
        if (pending_type_next == T_SD1) begin
          command_index_next = 6'd41; app_prefix_pending_next = 1'b1;
        end else begin
          command_index_next = 6'd1; app_prefix_pending_next = 1'b0;
        end
      end
    end
    // power-up wait over: dummy bytes or straight to CMD0
    if ((c == CMD_START || c == CMD_TICK) && phase_next == PH_POWERUP
        && init_timer_next == 8'd0) begin
      if (dummy_bytes == 8'd0) begin
        command_index_next = 6'd0; command_arg_next = '0;
        app_prefix_pending_next = 1'b0; init_step_next = ST_CMD0;
        phase_next = PH_DESEL;
      end else begin
        phase_next = PH_DUMMY; byte_count_next = dummy_bytes;
      end
    end

    idx = app_prefix_pending_next ? 6'd55 : command_index_next;
    arg = app_prefix_pending_next ? 32'd0 : command_arg_next;
    res.exchange_pending = (phase_next != PH_IDLE) && (phase_next != PH_POWERUP);
    res.select_low = (phase_next == PH_WAIT_FIRST) || (phase_next == PH_WAIT_READY) ||
                     (phase_next == PH_SEND) || (phase_next == PH_RESP) ||
                     (phase_next == PH_OCR);
    res.tx_byte = 8'hFF;
    if (phase_next == PH_SEND) begin
      unique case (byte_count_next)
        8'd0: res.tx_byte = {2'b01, idx};
        8'd1: res.tx_byte = arg[31:24];
        8'd2: res.tx_byte = arg[23:16];
        8'd3: res.tx_byte = arg[15:8];
        8'd4: res.tx_byte = arg[7:0];
        default: res.tx_byte = (idx == 6'd0) ? 8'h95 : ((idx == 6'd8) ? 8'h87 : 8'h01);
      endcase
    end
    res.fast_clock = clock_fast_next;
    res.busy_res = (phase_next != PH_IDLE);
    res.init_ok = !not_initialized_next;
    res.card_type = type_flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      powerup_ticks <= 8'd2; init_timeout_ticks <= 8'd100; ready_timeout_ticks <= 8'd50;
      response_tries <= 8'd10; dummy_bytes <= 8'd10; block_length <= 13'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POWERUP:  powerup_ticks <= cfg_data[7:0];
        REG_INIT_TO:  init_timeout_ticks <= cfg_data[7:0];
        REG_READY_TO: ready_timeout_ticks <= cfg_data[7:0];
        REG_TRIES:    response_tries <= cfg_data[7:0];
        REG_DUMMY:    dummy_bytes <= cfg_data[7:0];
        REG_BLKLEN:   block_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; byte_count <= '0; command_index <= '0; command_arg <= '0;
      app_prefix_pending <= 1'b0; tries_left <= '0; init_timer <= '0; ready_timer <= '0;
      for (int i = 0; i < 4; i++) ocr_bytes[i] <= '0;
      type_flags <= '0; not_initialized <= 1'b1; clock_fast <= 1'b0;
      init_step <= ST_CMD0; pending_type <= '0; m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        phase <= phase_next; byte_count <= byte_count_next;
        command_index <= command_index_next; command_arg <= command_arg_next;
        app_prefix_pending <= app_prefix_pending_next; tries_left <= tries_left_next;
        init_timer <= init_timer_next; ready_timer <= ready_timer_next;
        ocr_bytes <= ocr_bytes_next; type_flags <= type_flags_next;
        not_initialized <= not_initialized_next; clock_fast <= clock_fast_next;
        init_step <= init_step_next; pending_type <= pending_type_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) m_tdata <= {7'd0, res};
  end

  `SDI_ASSERT_NXT(a_result_follows, clk, rst, accept, m_tvalid)
  `SDI_ASSERT_IMP(a_idle_not_pending, clk, rst, phase == PH_IDLE,
    !res.exchange_pending || !(s_tdata[1:0] == CMD_XFER || s_tdata[1:0] == 2'd3))
  `SDI_ASSERT_IMP(a_ok_means_fast, clk, rst, !not_initialized, clock_fast || phase != PH_IDLE)
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import sdi_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [7:0] R1_IDLE = 8'h01;
  localparam logic [7:0] R1_READY = 8'h00;
  localparam logic [7:0] R1_ILLEGAL = 8'h05;
  localparam int KIND_SD2 = 0;
  localparam int KIND_SD1 = 1;
  localparam int KIND_MMC = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  sd_spi_card_init_sequencer dut (.*);

  always #5 clk = ~clk;

  // sequencer model: configuration
  logic [7:0]  c_powerup, c_init_to, c_ready_to, c_tries, c_dummy;
  logic [12:0] c_blklen;
  // sequencer model: state
  logic [3:0]  ph;
  logic [7:0]  cnt, tries, last_rsp, init_tmr, rdy_tmr;
  logic [6:0]  cmd_idx;
  logic [31:0] cmd_arg;
  logic        app_pend, not_init, clk_fast;
  logic [7:0]  ocr [4];
  logic [3:0]  tflags, ptype;
  logic [2:0]  step;

  result_t status_q[$];
  int  errors = 0;
  int  items_sent = 0;
  bit  s_calm = 0, m_calm = 0;
  int  kind = KIND_SD2;
  bit  noisy = 0;

  function automatic void model_reset();
    c_powerup = 8'd2; c_init_to = 8'd100; c_ready_to = 8'd50;
    c_tries = 8'd10; c_dummy = 8'd10; c_blklen = 13'd512;
    ph = PH_IDLE; cnt = '0; cmd_idx = '0; cmd_arg = '0; app_pend = 0;
    tries = '0; last_rsp = 8'hFF; init_tmr = '0; rdy_tmr = '0;
    for (int i = 0; i < 4; i++) ocr[i] = '0;
    tflags = '0; not_init = 1; clk_fast = 0; step = ST_CMD0; ptype = '0;
  endfunction

  function automatic void issue(logic [6:0] idx, logic [31:0] arg, logic app,
                                logic [2:0] st);
    cmd_idx = idx; cmd_arg = arg; app_pend = app; step = st; ph = PH_DESEL;
  endfunction

  function automatic void finish_init(logic [3:0] ty);
    tflags = ty; ph = PH_FINISH;
  endfunction

  function automatic void sd2_poll();
    if (init_tmr != 0) issue(7'd41, 32'h4000_0000, 1'b1, ST_SD2POLL);
    else finish_init('0);
  endfunction

  function automatic void old_poll();
    if (init_tmr == 0) finish_init('0);
    else if (ptype == T_SD1) issue(7'd41, '0, 1'b1, ST_OLDPOLL);
    else issue(7'd1, '0, 1'b0, ST_OLDPOLL);
  endfunction

  function automatic void answer(logic [7:0] r);
    case (step)
      ST_CMD0: begin
        if (r == 8'd1) begin
          init_tmr = c_init_to;
          issue(7'd8, 32'h1AA, 1'b0, ST_CMD8);
        end else finish_init('0);
      end
      ST_CMD8: begin
        if (r == 8'd1) begin
          ph = PH_OCR; cnt = '0;
        end else issue(7'd41, '0, 1'b1, ST_PROBE);
      end
      ST_SD2POLL: begin
        if (r != 0) sd2_poll();
        else if (init_tmr != 0) issue(7'd58, '0, 1'b0, ST_CMD58);
        else finish_init('0);
      end
      ST_CMD58: begin
        if (r == 0) begin
          ph = PH_OCR; cnt = '0;
        end else finish_init('0);
      end
      ST_PROBE: begin
        ptype = (r <= 8'd1) ? T_SD1 : T_MMC;
        old_poll();
      end
      ST_OLDPOLL: begin
        if (r != 0) old_poll();
        else if (init_tmr != 0) issue(7'd16, {19'd0, c_blklen}, 1'b0, ST_CMD16);
        else finish_init('0);
      end
      default: finish_init(r == 0 ? ptype : 4'd0);
    endcase
  endfunction

  // an APP_CMD prefix answer of 0 or 1 moves on to the command itself
  function automatic void response_done(logic [7:0] r);
    if (app_pend) begin
      app_pend = 0;
      if (r > 8'd1) answer(r);
      else ph = PH_DESEL;
    end else answer(r);
  endfunction

  function automatic void begin_dummy();
    if (c_dummy == 0) issue('0, '0, 1'b0, ST_CMD0);
    else begin
      ph = PH_DUMMY; cnt = c_dummy;
    end
  endfunction

  function automatic logic [7:0] frame_byte();
    logic [6:0]  idx;
    logic [31:0] arg;
    idx = app_pend ? 7'd55 : cmd_idx;
    arg = app_pend ? 32'd0 : cmd_arg;
    case (cnt)
      8'd0: return 8'h40 | {2'b00, idx[5:0]};
      8'd1: return arg[31:24];
      8'd2: return arg[23:16];
      8'd3: return arg[15:8];
      8'd4: return arg[7:0];
      default: return idx == 0 ? 8'h95 : (idx == 8 ? 8'h87 : 8'h01);
    endcase
  endfunction

  function automatic void exchange_done(logic [7:0] rx);
    case (ph)
      PH_DUMMY: begin
        cnt = cnt - 8'd1;
        if (cnt == 0) issue('0, '0, 1'b0, ST_CMD0);
      end
      PH_DESEL: begin
        rdy_tmr = c_ready_to; ph = PH_WAIT_FIRST;
      end
      PH_WAIT_FIRST: ph = PH_WAIT_READY;
      PH_WAIT_READY: begin
        if (rx == 8'hFF) begin
          ph = PH_SEND; cnt = '0;
        end else if (rdy_tmr == 0) ph = PH_FAIL_DESEL;
      end
      PH_FAIL_DESEL: begin
        last_rsp = 8'hFF; response_done(8'hFF);
      end
      PH_SEND: begin
        if (cnt >= 5) begin
          ph = PH_RESP; tries = c_tries;
        end else cnt = cnt + 8'd1;
      end
      PH_RESP: begin
        last_rsp = rx;
        tries = tries - 8'd1;
        if (!rx[7] || tries == 0) response_done(rx);
      end
      PH_OCR: begin
        ocr[cnt[1:0]] = rx;
        cnt = cnt + 8'd1;
        if (cnt >= 4) begin
          if (step == ST_CMD8) begin
            if (ocr[2] == 8'h01 && ocr[3] == 8'hAA) sd2_poll();
            else finish_init('0);
          end else finish_init(ocr[0][6] ? (T_SD2 | T_BLOCK) : T_SD2);
        end
      end
      PH_FINISH: begin
        if (tflags != 0) begin
          not_init = 0; clk_fast = 1;
        end else begin
          not_init = 1; clk_fast = 0;
        end
        ph = PH_IDLE;
      end
      default: ;
    endcase
  endfunction

  function automatic result_t predict_status(logic [1:0] c, logic [7:0] rx);
    result_t r;
    if (c == CMD_START) begin
      clk_fast = 0; app_pend = 0; init_tmr = c_powerup; ph = PH_POWERUP;
      if (init_tmr == 0) begin_dummy();
    end else if (c == CMD_XFER) begin
      exchange_done(rx);
    end else if (c == CMD_TICK) begin
      if (init_tmr != 0) init_tmr = init_tmr - 8'd1;
      if (rdy_tmr != 0) rdy_tmr = rdy_tmr - 8'd1;
      if (ph == PH_POWERUP && init_tmr == 0) begin_dummy();
    end
    r.exchange_pending = ph != PH_IDLE && ph != PH_POWERUP;
    r.select_low = ph inside {PH_WAIT_FIRST, PH_WAIT_READY, PH_SEND, PH_RESP, PH_OCR};
    r.tx_byte = (ph == PH_SEND) ? frame_byte() : 8'hFF;
    r.fast_clock = clk_fast;
    r.busy_res = ph != PH_IDLE;
    r.init_ok = !not_init;
    r.card_type = tflags;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] c, input logic [7:0] rx);
    int gap;
    gap = s_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, rx, c};
    do @(posedge clk); while (!s_tready);
    status_q.push_back(predict_status(c, rx));
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [12:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      REG_POWERUP:  c_powerup = val[7:0];
      REG_INIT_TO:  c_init_to = val[7:0];
      REG_READY_TO: c_ready_to = val[7:0];
      REG_TRIES:    c_tries = val[7:0];
      REG_DUMMY:    c_dummy = val[7:0];
      REG_BLKLEN:   c_blklen = val;
      default: ;
    endcase
  endtask

  // behave like a card of the chosen kind, answering what the sequencer asks next
  function automatic logic [7:0] card_byte();
    logic [7:0] any;
    any = 8'($urandom_range(0, 255));
    case (ph)
      PH_WAIT_READY: return ($urandom_range(0, noisy ? 2 : 9) == 0) ? 8'h00 : 8'hFF;
      PH_RESP: begin
        if ($urandom_range(0, 3) == 0) return 8'h80 | any;
        if (noisy && $urandom_range(0, 9) == 0) return any;
        if (app_pend) return (noisy && $urandom_range(0, 7) == 0) ? R1_ILLEGAL : R1_IDLE;
        case (step)
          ST_CMD0:    return R1_IDLE;
          ST_CMD8:    return kind == KIND_SD2 ? R1_IDLE : R1_ILLEGAL;
          ST_PROBE:   return kind == KIND_SD1 ? R1_IDLE : R1_ILLEGAL;
          ST_SD2POLL,
          ST_OLDPOLL: return $urandom_range(0, 1) ? R1_READY : R1_IDLE;
          default:    return R1_READY;
        endcase
      end
      PH_OCR: begin
        if (noisy && $urandom_range(0, 9) == 0) return any;
        if (step == ST_CMD8 && cnt == 2) return 8'h01;
        if (step == ST_CMD8 && cnt == 3) return 8'hAA;
        return any;
      end
      PH_IDLE, PH_POWERUP: return any;
      default: return noisy ? any : 8'hFF;
    endcase
  endfunction

  task automatic run_init(input int k, input bit n);
    kind = k; noisy = n;
    send_item(CMD_START, 8'($urandom_range(0, 255)));
    while (ph != PH_IDLE) begin
      if (ph == PH_POWERUP || $urandom_range(0, n ? 30 : 60) == 0)
        send_item(CMD_TICK, 8'($urandom_range(0, 255)));
      else if (n && $urandom_range(0, 300) == 0)
        send_item(CMD_NONE, 8'($urandom_range(0, 255)));
      else if (n && $urandom_range(0, 400) == 0)
        send_item(CMD_START, 8'($urandom_range(0, 255)));
      else
        send_item(CMD_XFER, card_byte());
    end
  endtask

  task automatic test_idle_items();
    send_item(CMD_XFER, 8'h00);
    send_item(CMD_XFER, 8'hFF);
    send_item(CMD_TICK, 8'hA5);
    send_item(CMD_NONE, 8'h5A);
    // restart while busy
    send_item(CMD_START, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_START, 8'hFF);
    repeat (3) send_item(CMD_TICK, 8'h00);
    send_item(CMD_XFER, 8'hFF);
    send_item(CMD_START, 8'h00);
    drain();
  endtask

  task automatic test_card_kinds();
    run_init(KIND_SD2, 0);
    run_init(KIND_SD1, 0);
    run_init(KIND_MMC, 0);
    drain();
  endtask

  task automatic test_zero_settings();
    set_reg(REG_POWERUP, 13'd0);
    set_reg(REG_DUMMY, 13'd0);
    set_reg(REG_TRIES, 13'd0);
    run_init(KIND_SD2, 0);
    set_reg(REG_DUMMY, 13'd1);
    set_reg(REG_TRIES, 13'd1);
    run_init(KIND_SD1, 1);
    drain();
  endtask

  task automatic test_extremes();
    set_reg(REG_POWERUP, 13'd255);
    set_reg(REG_INIT_TO, 13'd255);
    set_reg(REG_READY_TO, 13'd255);
    set_reg(REG_TRIES, 13'd255);
    set_reg(REG_DUMMY, 13'd255);
    set_reg(REG_BLKLEN, 13'd4096);
    run_init(KIND_MMC, 0);
    set_reg(REG_POWERUP, 13'd1);
    set_reg(REG_INIT_TO, 13'd1);
    set_reg(REG_READY_TO, 13'd1);
    set_reg(REG_DUMMY, 13'd1);
    set_reg(REG_BLKLEN, 13'd1);
    run_init(KIND_SD1, 1);
    run_init(KIND_SD2, 1);
    drain();
  endtask

  task automatic test_random();
    int start_count;
    start_count = items_sent;
    while (items_sent - start_count < 100) begin
      set_reg(REG_POWERUP, 13'($urandom_range(0, 3)));
      set_reg(REG_INIT_TO, 13'($urandom_range(0, 3) == 0 ? $urandom_range(1, 4)
                                                          : $urandom_range(20, 255)));
      set_reg(REG_READY_TO, 13'($urandom_range(1, 255)));
      set_reg(REG_TRIES, 13'($urandom_range(0, 12)));
      set_reg(REG_DUMMY, 13'($urandom_range(0, 4)));
      set_reg(REG_BLKLEN, 13'($urandom_range(1, 4096)));
      s_calm = $urandom_range(0, 3) == 0;
      m_calm = $urandom_range(0, 3) == 0;
      repeat ($urandom_range(1, 3))
        run_init($urandom_range(0, 2), $urandom_range(0, 2) == 0);
      if ($urandom_range(0, 3) == 0) send_item(CMD_NONE, 8'($urandom_range(0, 255)));
    end
    drain();
  endtask

  task automatic field_error(input string name, input int want, input int got);
    $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
    errors++;
  endtask

  // result side: random stalls, compare each taken item with the oldest prediction
  initial begin
    int gap;
    result_t got, want;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = m_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata[16:0];
      if (status_q.size() == 0) begin
        $display("%0t unexpected item: expected none actual %h", $time, got);
        errors++;
      end else begin
        want = status_q.pop_front();
        if (got.exchange_pending !== want.exchange_pending)
          field_error("exchange_pending", want.exchange_pending, got.exchange_pending);
        if (got.tx_byte !== want.tx_byte) field_error("tx_byte", want.tx_byte, got.tx_byte);
        if (got.select_low !== want.select_low)
          field_error("select_low", want.select_low, got.select_low);
        if (got.fast_clock !== want.fast_clock)
          field_error("fast_clock", want.fast_clock, got.fast_clock);
        if (got.busy_res !== want.busy_res)
          field_error("busy_res", want.busy_res, got.busy_res);
        if (got.init_ok !== want.init_ok) field_error("init_ok", want.init_ok, got.init_ok);
        if (got.card_type !== want.card_type)
          field_error("card_type", want.card_type, got.card_type);
      end
      @(negedge clk);
    end
  end

  initial begin
    model_reset();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_idle_items();
    test_card_kinds();
    test_zero_settings();
    test_extremes();
    test_random();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/sdi_pkg.sv
sv/sd_spi_card_init_sequencer.sv
tb/tb.sv
